FILE: rtl/core/epo_pkg.sv
// Shared constants, control codes and controller/datapath interface types for the echo peak unit.
`default_nettype none
package epo_pkg;

   localparam int MAX_LINE_SAMPLES = 1024;
   localparam int MAX_LINES        = 65535;
   localparam int NOISE_FACTOR     = 10;

   localparam int SAMPLE_W   = 16;
   localparam int ECHO_W     = 8;
   localparam int POS_W      = $clog2(MAX_LINE_SAMPLES);
   localparam int CNT_W      = 16;
   localparam int SUM_W      = POS_W + CNT_W;
   localparam int SQ_W       = 2 * SAMPLE_W - 1;
   localparam int POWER_W    = 32;
   localparam int THR_W      = POWER_W + 4;
   localparam int FRAC_W     = 8;
   localparam int DIVIDEND_W = SUM_W + FRAC_W;
   localparam int QUO_W      = 18;
   localparam int DIFF_W     = QUO_W + 1;
   localparam int NAV_W      = 4;
   localparam int SEG_W      = 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 88;
   localparam int RSP_TUSER_W = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_NOISE_POWER       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAVIGATOR_ECHOES  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_COUNT     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALTERNATE_READOUT = 2'd3;

   typedef struct packed {
      logic accept;      // request taken into the first stage
      logic div_start;   // load the divider
      logic div_even;    // divider operand select: even class
      logic latch_odd;   // store the odd-class quotient
      logic load_out;    // form the result and clear the accumulators
   } ctrl_cmd_type;

   typedef struct packed {
      logic s1_set_end;  // first stage holds the closing request of a set
      logic div_done;    // divider quotient ready
      logic out_full;    // output register still waiting
   } ctrl_sts_type;

endpackage
`default_nettype wire

FILE: rtl/core/epo_div.sv
// Bit-serial restoring divider that produces one quotient bit per cycle.
`default_nettype none
module epo_div (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire [epo_pkg::DIVIDEND_W-1:0]    dividend,
   input  wire [epo_pkg::CNT_W-1:0]         divisor,
   output logic                             done,
   output logic [epo_pkg::QUO_W-1:0]        quotient
);

   localparam int STEP_W = $clog2(epo_pkg::QUO_W + 1);

   logic [epo_pkg::CNT_W-1:0] rem_ff, rem_in;
   logic [epo_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [epo_pkg::CNT_W-1:0] divisor_ff, divisor_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic [epo_pkg::CNT_W:0]   trial;
   logic [epo_pkg::CNT_W:0]   trial_diff;
   logic                      trial_fits;

   // The quotient is known to fit QUO_W bits, so the top of the dividend seeds the remainder
   always_comb begin
      trial      = {rem_ff, quo_ff[epo_pkg::QUO_W-1]};
      trial_diff = trial - {1'b0, divisor_ff};
      trial_fits = trial >= {1'b0, divisor_ff};

      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;

      if (start) begin
         rem_in     = dividend[epo_pkg::DIVIDEND_W-1:epo_pkg::QUO_W];
         quo_in     = dividend[epo_pkg::QUO_W-1:0];
         divisor_in = divisor;
         step_in    = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = trial_fits ? trial_diff[epo_pkg::CNT_W-1:0] : trial[epo_pkg::CNT_W-1:0];
         quo_in  = {quo_ff[epo_pkg::QUO_W-2:0], trial_fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(epo_pkg::QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider finished without running");

   a_done_clears_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider still busy after finishing");

   a_start_begins: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && step_ff == '0)
      else $error("divider did not load on start");

endmodule
`default_nettype wire

FILE: rtl/core/epo_datapath.sv
// Datapath: squared magnitude, line peak search, parity sums, mean division and result register.
`default_nettype none
module epo_datapath (
   input  wire                                    clock,
   input  wire                                    reset,
   input  epo_pkg::ctrl_cmd_type                  cmd,
   output epo_pkg::ctrl_sts_type                  sts,
   input  wire signed [epo_pkg::SAMPLE_W-1:0]     sample_real,
   input  wire signed [epo_pkg::SAMPLE_W-1:0]     sample_imag,
   input  wire [epo_pkg::ECHO_W-1:0]              echo_number,
   input  wire                                    odd_segment,
   input  wire                                    line_end,
   input  wire                                    set_end,
   input  wire                                    csr_wr_en,
   input  wire [epo_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire [epo_pkg::CSR_DATA_W-1:0]          csr_data,
   input  wire                                    rsp_tready,
   output logic                                   rsp_tvalid,
   output logic [epo_pkg::QUO_W-1:0]              odd_mean_q8,
   output logic [epo_pkg::QUO_W-1:0]              even_mean_q8,
   output logic signed [epo_pkg::DIFF_W-1:0]      mean_difference_q8,
   output logic [epo_pkg::CNT_W-1:0]              odd_lines,
   output logic [epo_pkg::CNT_W-1:0]              even_lines,
   output logic                                   odd_empty,
   output logic                                   even_empty
);

   localparam int POS_W  = epo_pkg::POS_W;
   localparam int CNT_W  = epo_pkg::CNT_W;
   localparam int SUM_W  = epo_pkg::SUM_W;
   localparam int QUO_W  = epo_pkg::QUO_W;
   localparam int DIFF_W = epo_pkg::DIFF_W;
   localparam int THR_W  = epo_pkg::THR_W;
   localparam int PWR_W  = epo_pkg::POWER_W;
   localparam int SQ_W   = epo_pkg::SQ_W;
   localparam int DVD_W  = epo_pkg::DIVIDEND_W;

   // Configuration
   logic [THR_W-1:0]         threshold_ff;
   logic [epo_pkg::NAV_W-1:0] nav_ff;
   logic [epo_pkg::SEG_W-1:0] seg_ff;
   logic                     alt_ff;
   logic [THR_W-1:0]         noise_ext;
   logic [THR_W-1:0]         threshold_in;
   logic                     alt_enable;

   // First stage
   logic                     s1_valid_ff;
   logic [SQ_W-1:0]          s1_sq_re_ff, s1_sq_im_ff;
   logic [epo_pkg::ECHO_W-1:0] s1_echo_ff;
   logic                     s1_odd_seg_ff, s1_line_end_ff, s1_set_end_ff;
   logic signed [2*epo_pkg::SAMPLE_W-1:0] re_sq, im_sq;

   // Line state
   logic [POS_W-1:0]         sample_pos_ff, sample_pos_in;
   logic [PWR_W-1:0]         best_power_ff, best_power_in;
   logic [POS_W-1:0]         best_pos_ff, best_pos_in;
   logic                     peak_found_ff, peak_found_in;

   // Accumulators
   logic [SUM_W-1:0]         odd_sum_ff, odd_sum_in, even_sum_ff, even_sum_in;
   logic [CNT_W-1:0]         odd_cnt_ff, odd_cnt_in, even_cnt_ff, even_cnt_in;

   logic [PWR_W-1:0]         power;
   logic                     beats;
   logic                     line_close;
   logic                     peak_now;
   logic [POS_W-1:0]         pos_now;
   logic                     parity;

   // Division
   logic [SUM_W-1:0]         div_sum;
   logic [CNT_W-1:0]         div_cnt;
   logic [DVD_W-1:0]         dividend;
   logic                     div_done;
   logic [QUO_W-1:0]         div_quotient;
   logic [QUO_W-1:0]         odd_quo_ff;

   // Result
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     res_odd_empty, res_even_empty;
   logic [QUO_W-1:0]         res_odd_mean, res_even_mean;
   logic [DIFF_W-1:0]        res_diff;

   assign noise_ext    = {{(THR_W-epo_pkg::CSR_DATA_W){1'b0}}, csr_data};
   assign threshold_in = (noise_ext << 3) + (noise_ext << 1);
   assign alt_enable   = alt_ff && (seg_ff > epo_pkg::SEG_W'(1)) && seg_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         nav_ff       <= '0;
         seg_ff       <= epo_pkg::SEG_W'(1);
         alt_ff       <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            epo_pkg::CSR_NOISE_POWER:       threshold_ff <= threshold_in;
            epo_pkg::CSR_NAVIGATOR_ECHOES:  nav_ff <= csr_data[epo_pkg::NAV_W-1:0];
            epo_pkg::CSR_SEGMENT_COUNT:     seg_ff <= csr_data[epo_pkg::SEG_W-1:0];
            epo_pkg::CSR_ALTERNATE_READOUT: alt_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Stage one: squares only
   assign re_sq = sample_real * sample_real;
   assign im_sq = sample_imag * sample_imag;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.accept;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         s1_sq_re_ff    <= re_sq[SQ_W-1:0];
         s1_sq_im_ff    <= im_sq[SQ_W-1:0];
         s1_echo_ff     <= echo_number;
         s1_odd_seg_ff  <= odd_segment;
         s1_line_end_ff <= line_end;
         s1_set_end_ff  <= set_end;
      end
   end

   // Stage two: peak update and class accumulation
   always_comb begin
      power      = {1'b0, s1_sq_re_ff} + {1'b0, s1_sq_im_ff};
      beats      = (power > best_power_ff) &&
                   ({{(THR_W-PWR_W){1'b0}}, power} > threshold_ff);
      line_close = s1_line_end_ff || s1_set_end_ff;
      peak_now   = peak_found_ff || beats;
      pos_now    = beats ? sample_pos_ff : best_pos_ff;
      // even parity index means an odd echo
      parity     = s1_echo_ff[0] ^ (alt_enable && s1_odd_seg_ff) ^
                   ({{(epo_pkg::ECHO_W-epo_pkg::NAV_W){1'b0}}, nav_ff} <= s1_echo_ff);

      sample_pos_in = sample_pos_ff;
      best_power_in = best_power_ff;
      best_pos_in   = best_pos_ff;
      peak_found_in = peak_found_ff;
      odd_sum_in    = odd_sum_ff;
      even_sum_in   = even_sum_ff;
      odd_cnt_in    = odd_cnt_ff;
      even_cnt_in   = even_cnt_ff;

      if (s1_valid_ff) begin
         if (line_close) begin
            sample_pos_in = '0;
            best_power_in = '0;
            best_pos_in   = '0;
            peak_found_in = 1'b0;
            if (peak_now) begin
               if (!parity) begin
                  if (odd_cnt_ff < CNT_W'(epo_pkg::MAX_LINES)) begin
                     odd_sum_in = odd_sum_ff + {{(SUM_W-POS_W){1'b0}}, pos_now};
                     odd_cnt_in = odd_cnt_ff + CNT_W'(1);
                  end
               end else begin
                  if (even_cnt_ff < CNT_W'(epo_pkg::MAX_LINES)) begin
                     even_sum_in = even_sum_ff + {{(SUM_W-POS_W){1'b0}}, pos_now};
                     even_cnt_in = even_cnt_ff + CNT_W'(1);
                  end
               end
            end
         end else begin
            if (beats) begin
               best_power_in = power;
               best_pos_in   = sample_pos_ff;
               peak_found_in = 1'b1;
            end
            if (sample_pos_ff < POS_W'(epo_pkg::MAX_LINE_SAMPLES - 1)) begin
               sample_pos_in = sample_pos_ff + POS_W'(1);
            end
         end
      end

      if (cmd.load_out) begin
         odd_sum_in  = '0;
         even_sum_in = '0;
         odd_cnt_in  = '0;
         even_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_pos_ff <= '0;
         best_power_ff <= '0;
         best_pos_ff   <= '0;
         peak_found_ff <= 1'b0;
         odd_sum_ff    <= '0;
         even_sum_ff   <= '0;
         odd_cnt_ff    <= '0;
         even_cnt_ff   <= '0;
      end else begin
         sample_pos_ff <= sample_pos_in;
         best_power_ff <= best_power_in;
         best_pos_ff   <= best_pos_in;
         peak_found_ff <= peak_found_in;
         odd_sum_ff    <= odd_sum_in;
         even_sum_ff   <= even_sum_in;
         odd_cnt_ff    <= odd_cnt_in;
         even_cnt_ff   <= even_cnt_in;
      end
   end

   // Mean with half-up rounding: (sum * 256 + count / 2) / count
   assign div_sum  = cmd.div_even ? even_sum_ff : odd_sum_ff;
   assign div_cnt  = cmd.div_even ? even_cnt_ff : odd_cnt_ff;
   assign dividend = {div_sum, {epo_pkg::FRAC_W{1'b0}}} +
                     {{(DVD_W-CNT_W+1){1'b0}}, div_cnt[CNT_W-1:1]};

   epo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (div_cnt),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.latch_odd) begin
         odd_quo_ff <= div_quotient;
      end
   end

   // Result register
   always_comb begin
      res_odd_empty  = odd_cnt_ff == '0;
      res_even_empty = even_cnt_ff == '0;
      res_odd_mean   = res_odd_empty ? '0 : odd_quo_ff;
      res_even_mean  = res_even_empty ? '0 : div_quotient;
      res_diff       = (res_odd_empty || res_even_empty) ? '0 :
                       ({1'b0, res_odd_mean} - {1'b0, res_even_mean});
      rsp_valid_in   = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         odd_mean_q8        <= res_odd_mean;
         even_mean_q8       <= res_even_mean;
         mean_difference_q8 <= $signed(res_diff);
         odd_lines          <= odd_cnt_ff;
         even_lines         <= even_cnt_ff;
         odd_empty          <= res_odd_empty;
         even_empty         <= res_even_empty;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign sts.s1_set_end = s1_valid_ff && s1_set_end_ff;
   assign sts.div_done   = div_done;
   assign sts.out_full   = rsp_valid_ff;

   a_line_cleared: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && line_close) |=> (sample_pos_ff == '0) && !peak_found_ff)
      else $error("line state not cleared after line close");

   a_set_clears_sums: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (odd_cnt_ff == '0) && (even_cnt_ff == '0) && rsp_valid_ff)
      else $error("accumulators not cleared when result formed");

   a_no_sample_in_division: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_start || cmd.load_out) |-> !s1_valid_ff)
      else $error("sample in flight while the set is being closed");

endmodule
`default_nettype wire

FILE: rtl/core/epo_ctrl.sv
// Controller: request acceptance and set-end sequencing of the two mean divisions.
`default_nettype none
module epo_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   input  wire                    req_set_end,
   output logic                   req_tready,
   output epo_pkg::ctrl_cmd_type  cmd,
   input  epo_pkg::ctrl_sts_type  sts
);

   localparam logic [2:0] ST_RUN       = 3'd0;
   localparam logic [2:0] ST_FLUSH     = 3'd1;
   localparam logic [2:0] ST_ODD_GO    = 3'd2;
   localparam logic [2:0] ST_ODD_WAIT  = 3'd3;
   localparam logic [2:0] ST_EVEN_WAIT = 3'd4;
   localparam logic [2:0] ST_OUT       = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.accept    = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_even  = 1'b0;
      cmd.latch_odd = 1'b0;
      cmd.load_out  = 1'b0;

      case (state_ff)
         ST_RUN: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && req_set_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // let the closing request reach the accumulators
            if (sts.s1_set_end) begin
               state_in = ST_ODD_GO;
            end
         end
         ST_ODD_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_ODD_WAIT;
         end
         ST_ODD_WAIT: begin
            if (sts.div_done) begin
               cmd.latch_odd = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_even  = 1'b1;
               state_in      = ST_EVEN_WAIT;
            end
         end
         ST_EVEN_WAIT: begin
            cmd.div_even = 1'b1;
            if (sts.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the previous result has been taken
            if (!sts.out_full) begin
               cmd.load_out = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   a_set_end_stops_intake: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_set_end) |=> sts.s1_set_end && !req_tready)
      else $error("intake not stopped after set end");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !sts.out_full)
      else $error("result overwritten before it was taken");

   a_start_not_repeated: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !cmd.div_start)
      else $error("divider restarted on consecutive cycles");

endmodule
`default_nettype wire

FILE: rtl/core/epi_echo_peak_parity_offset_unit.sv
// Top level of the echo peak parity offset unit: stream ports, controller and datapath.
//
// Takes one complex sample a cycle while a set is running; each sample has its squares
// registered in the first stage before the peak search and class accumulation. A request
// with set end closes the set: req_tready then stays low while the odd and even means are
// formed one after the other by a shared bit-serial divider (18 quotient bits, one per
// cycle), and the result is loaded into the output register. A waiting result does not
// block sample intake; only the next set end waits for it to be taken. Configuration
// writes take effect at the next clock edge.
`default_nettype none
module epi_echo_peak_parity_offset_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // sample_real[15:0], sample_imag[31:16], echo_number[39:32]
   input  wire [epo_pkg::REQ_TDATA_W-1:0]       req_tdata,
   // odd_segment[0], set_end[1]
   input  wire [epo_pkg::REQ_TUSER_W-1:0]       req_tuser,
   input  wire                                  req_tlast,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // odd_mean_q8[17:0], even_mean_q8[35:18], mean_difference_q8[54:36],
   // odd_lines[70:55], even_lines[86:71], zero[87]
   output logic [epo_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // odd_empty[0], even_empty[1]
   output logic [epo_pkg::RSP_TUSER_W-1:0]      rsp_tuser,
   input  wire                                  csr_wr_en,
   input  wire [epo_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [epo_pkg::CSR_DATA_W-1:0]        csr_data
);

   epo_pkg::ctrl_cmd_type cmd;
   epo_pkg::ctrl_sts_type sts;

   logic [epo_pkg::QUO_W-1:0]         odd_mean_q8, even_mean_q8;
   logic signed [epo_pkg::DIFF_W-1:0] mean_difference_q8;
   logic [epo_pkg::CNT_W-1:0]         odd_lines, even_lines;
   logic                              odd_empty, even_empty;

   epo_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_set_end (req_tuser[1]),
      .req_tready  (req_tready),
      .cmd         (cmd),
      .sts         (sts)
   );

   epo_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .sample_real        ($signed(req_tdata[15:0])),
      .sample_imag        ($signed(req_tdata[31:16])),
      .echo_number        (req_tdata[39:32]),
      .odd_segment        (req_tuser[0]),
      .line_end           (req_tlast),
      .set_end            (req_tuser[1]),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .odd_mean_q8        (odd_mean_q8),
      .even_mean_q8       (even_mean_q8),
      .mean_difference_q8 (mean_difference_q8),
      .odd_lines          (odd_lines),
      .even_lines         (even_lines),
      .odd_empty          (odd_empty),
      .even_empty         (even_empty)
   );

   assign rsp_tdata = {1'b0, even_lines, odd_lines, mean_difference_q8,
                       even_mean_q8, odd_mean_q8};
   assign rsp_tuser = {even_empty, odd_empty};

endmodule
`default_nettype wire
